[hw/rtl/frdc_pkg.sv]
package frdc_pkg;

    // Built number of entry cells
    localparam int DEPTH = 16;

    localparam int ID_W  = 32;
    localparam int CAP_W = 5;
    localparam int OCC_W = 5;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_DUMP   = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef logic [ID_W-1:0]  ident_t;
    typedef logic [CNT_W-1:0] count_t;

    typedef struct packed {
        logic shift;   // insert: take the left neighbor
        logic rotate;  // dump: take the right neighbor
        logic wrap;    // dump: tail of the ring takes the head
        logic in_use;  // cell holds a live entry
    } frdc_cell_ctrl_t;

endpackage

[hw/rtl/frdc_if.sv]
interface frdc_in_if;
    import frdc_pkg::*;

    logic   valid;
    logic   ready;
    logic   func;
    ident_t ident;

    modport source (output valid, output func, output ident, input ready);
    modport sink   (input valid, input func, input ident, output ready);
endinterface

interface frdc_out_if;
    import frdc_pkg::*;

    logic             valid;
    logic             ready;
    logic             hit;
    logic             evicted_valid;
    ident_t           evicted_ident;
    logic [OCC_W-1:0] occupancy;
    logic             entry_valid;
    ident_t           entry_ident;
    logic             last;

    modport source (
        output valid, output hit, output evicted_valid, output evicted_ident,
        output occupancy, output entry_valid, output entry_ident, output last,
        input ready
    );
    modport sink (
        input valid, input hit, input evicted_valid, input evicted_ident,
        input occupancy, input entry_valid, input entry_ident, input last,
        output ready
    );
endinterface

[hw/rtl/frdc_cell.sv]
module frdc_cell (
    input  logic                      clk,
    input  frdc_pkg::frdc_cell_ctrl_t ctrl,
    input  frdc_pkg::ident_t          left_ident,
    input  frdc_pkg::ident_t          right_ident,
    input  frdc_pkg::ident_t          head_ident,
    input  frdc_pkg::ident_t          probe_ident,
    output frdc_pkg::ident_t          ident,
    output logic                      match
);
    import frdc_pkg::*;

    ident_t ident_reg;
    ident_t ident_next;

    always_comb
    begin
        ident_next = ident_reg;
        if (ctrl.shift)
        begin
            ident_next = left_ident;
        end
        else if (ctrl.rotate)
        begin
            ident_next = ctrl.wrap ? head_ident : right_ident;
        end
    end

    always_ff @(posedge clk)
    begin
        ident_reg <= ident_next;
    end

    assign ident = ident_reg;
    assign match = ctrl.in_use && (ident_reg == probe_ident);

endmodule

[hw/rtl/fifo_distinct_recent_cache_unit.sv]
// FIFO-replacement fully associative cache of distinct 32-bit identifiers,
// built as a chain of entry cells with the newest entry in cell 0. An arrival
// (func 0) is compared against every live cell at once and, on a miss,
// shifts the chain by one cell and inserts at the head, evicting the tail
// when the occupancy has reached the capacity register (0 reads as 1, values
// above the built depth read as the depth). An arrival gives one result. A
// dump (func 1) rotates the live part of the chain one cell per cycle while
// the output register is free and gives one result per held entry, newest
// first, last one marked; no new item is taken until its final result is in
// the output register. An empty dump gives one result with entry_valid low.
// Results sit in an output register, so a waiting result holds back at most
// the next item. Write capacity only while the block is idle; lowering it
// below the occupancy drops nothing until later misses.
module fifo_distinct_recent_cache_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [frdc_pkg::CAP_W-1:0]  cfg_wr_data,
    frdc_in_if.sink                     req,
    frdc_out_if.source                  rsp
);
    import frdc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic [CAP_W-1:0] capacity_reg;
    logic             state_reg;
    logic             state_next;
    count_t           count_reg;
    count_t           count_next;
    count_t           dump_idx_reg;
    count_t           dump_idx_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             hit_reg;
    logic             hit_next;
    logic             ev_valid_reg;
    logic             ev_valid_next;
    ident_t           ev_ident_reg;
    ident_t           ev_ident_next;
    count_t           occ_reg;
    count_t           occ_next;
    logic             en_valid_reg;
    logic             en_valid_next;
    ident_t           en_ident_reg;
    ident_t           en_ident_next;
    logic             last_reg;
    logic             last_next;

    ident_t           cell_ident [DEPTH];
    logic [DEPTH-1:0] cell_match;
    logic             shift_all;
    logic             rotate_all;
    logic             out_free;
    logic             accept;
    logic             hit_any;
    count_t           eff_cap;
    logic             evict;
    logic [IDX_W-1:0] tail_idx;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign hit_any   = |cell_match;
    assign tail_idx  = IDX_W'(count_reg - count_t'(1));
    assign evict     = (count_reg >= eff_cap);

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = count_t'(1);
        end
        else if (32'(capacity_reg) > 32'(DEPTH))
        begin
            eff_cap = count_t'(DEPTH);
        end
        else
        begin
            eff_cap = count_t'(capacity_reg);
        end
    end

    // Entry chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        frdc_cell_ctrl_t ctrl;
        ident_t          left_ident;
        ident_t          right_ident;

        if (i == 0)
        begin : g_head
            assign left_ident = req.ident;
        end
        else
        begin : g_body
            assign left_ident = cell_ident[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_ident = cell_ident[0];
        end
        else
        begin : g_mid
            assign right_ident = cell_ident[i+1];
        end

        assign ctrl.shift  = shift_all;
        assign ctrl.in_use = (count_t'(i) < count_reg);
        assign ctrl.rotate = rotate_all && ctrl.in_use;
        assign ctrl.wrap   = (count_t'(i) == count_reg - count_t'(1));

        frdc_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .left_ident  (left_ident),
            .right_ident (right_ident),
            .head_ident  (cell_ident[0]),
            .probe_ident (req.ident),
            .ident       (cell_ident[i]),
            .match       (cell_match[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        hit_next       = hit_reg;
        ev_valid_next  = ev_valid_reg;
        ev_ident_next  = ev_ident_reg;
        occ_next       = occ_reg;
        en_valid_next  = en_valid_reg;
        en_ident_next  = en_ident_reg;
        last_next      = last_reg;
        shift_all      = 1'b0;
        rotate_all     = 1'b0;

        if (accept)
        begin
            if (req.func == FUNC_ARRIVE)
            begin
                out_valid_next = 1'b1;
                hit_next       = hit_any;
                ev_valid_next  = 1'b0;
                ev_ident_next  = '0;
                en_valid_next  = 1'b0;
                en_ident_next  = '0;
                last_next      = 1'b1;
                if (!hit_any)
                begin
                    shift_all = 1'b1;
                    if (evict)
                    begin
                        ev_valid_next = 1'b1;
                        ev_ident_next = cell_ident[tail_idx];
                    end
                    else
                    begin
                        count_next = count_reg + count_t'(1);
                    end
                end
                occ_next = count_next;
            end
            else if (count_reg == '0)
            begin
                out_valid_next = 1'b1;
                hit_next       = 1'b0;
                ev_valid_next  = 1'b0;
                ev_ident_next  = '0;
                occ_next       = '0;
                en_valid_next  = 1'b0;
                en_ident_next  = '0;
                last_next      = 1'b1;
            end
            else
            begin
                state_next    = ST_DUMP;
                dump_idx_next = '0;
            end
        end

        // Emit the head and rotate the live ring toward it
        if (state_reg == ST_DUMP && out_free)
        begin
            out_valid_next = 1'b1;
            rotate_all     = 1'b1;
            hit_next       = 1'b0;
            ev_valid_next  = 1'b0;
            ev_ident_next  = '0;
            occ_next       = count_reg;
            en_valid_next  = 1'b1;
            en_ident_next  = cell_ident[0];
            last_next      = (dump_idx_reg == count_reg - count_t'(1));
            if (last_next)
            begin
                state_next    = ST_IDLE;
                dump_idx_next = '0;
            end
            else
            begin
                dump_idx_next = dump_idx_reg + count_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        ev_valid_reg <= ev_valid_next;
        ev_ident_reg <= ev_ident_next;
        occ_reg      <= occ_next;
        en_valid_reg <= en_valid_next;
        en_ident_reg <= en_ident_next;
        last_reg     <= last_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = hit_reg;
    assign rsp.evicted_valid = ev_valid_reg;
    assign rsp.evicted_ident = ev_ident_reg;
    assign rsp.occupancy     = OCC_W'(occ_reg);
    assign rsp.entry_valid   = en_valid_reg;
    assign rsp.entry_ident   = en_ident_reg;
    assign rsp.last          = last_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(DEPTH))
        else $error("occupancy above built depth");

    a_dump_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |-> count_reg != '0)
        else $error("dump running on an empty store");

    a_hit_no_evict : assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.hit |-> !rsp.evicted_valid && rsp.last)
        else $error("hit reported with an eviction");

    a_arrive_result : assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.func == FUNC_ARRIVE |=> rsp.valid && rsp.last && !rsp.entry_valid)
        else $error("arrival transfer did not produce its result");

    a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + count_t'(1))
        else $error("occupancy moved by other than one insert");

endmodule
